// File: src/cds_pkg.sv
// Shared types, constants and saturating helpers for the critically damped smoother.
// Used by cds_mul, cds_div and critically_damped_smoother_unit.
`timescale 1ns / 1ps

package cds_pkg;

  // Default fraction width of every Q-format value
  localparam int FRAC_BITS_DEF = 16;

  // Request handed to the serial multiplier
  typedef struct packed {
    logic [31:0] a;    // magnitude operand
    logic [31:0] b;    // unsigned operand, shifted out one bit a cycle
    logic        neg;  // sign to put back on the product
  } mul_req_t;

  // Clamp a 34-bit signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Unsigned add clamped to 2^31-1
  function automatic logic [31:0] usat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    logic [31:0] r;
    sum = {1'b0, a} + {1'b0, b};
    r = (sum > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : sum[31:0];
    return r;
  endfunction

  // Magnitude of a signed 32-bit value (2^31 fits unsigned)
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

// File: src/cds_mul.sv
// Bit-serial shift-add multiplier with Q-format scaling and saturation.
// Depends on cds_pkg (mul_req_t).
`timescale 1ns / 1ps

module cds_mul #(
  parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cds_pkg::mul_req_t req,
  output logic              done,
  output logic signed [31:0] res
);

  logic        busy;
  logic        fin;
  logic [4:0]  cnt;
  logic [63:0] prod;
  logic [31:0] a_reg;
  logic        neg_reg;

  logic [32:0]        sum33;
  logic [63:0]        prod_next;
  logic [63:0]        shifted;
  logic [31:0]        mag;
  logic signed [31:0] res_next;

  // One multiplier bit per cycle: add into the high half, shift right
  always_comb begin
    sum33     = {1'b0, prod[63:32]} + (prod[0] ? {1'b0, a_reg} : 33'd0);
    prod_next = {sum33, prod[31:1]};
  end

  // Scale, truncate the magnitude, saturate, restore the sign
  always_comb begin
    shifted = prod >> FRAC_BITS;
    if (neg_reg) begin
      mag      = (shifted > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : shifted[31:0];
      res_next = ~mag + 32'd1;
    end else begin
      mag      = 32'd0;
      res_next = (shifted > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        prod    <= {32'd0, req.b};
        a_reg   <= req.a;
        neg_reg <= req.neg;
      end else if (busy) begin
        prod <= prod_next;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        res  <= res_next;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: src/cds_div.sv
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^31-1.
// Depends on cds_pkg (default fraction width).
`timescale 1ns / 1ps

module cds_div #(
  parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF,
  localparam int NUM_W = 2 * FRAC_BITS + 2,
  localparam int CW    = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic             done,
  output logic [31:0]      quo
);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] shreg;
  logic [31:0]      rem;
  logic [31:0]      dvs;

  logic [32:0] trial;
  logic        fits;
  logic [63:0] q64;

  // Bring down the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, shreg[NUM_W-1]};
    fits  = (trial >= {1'b0, dvs});
    q64   = 64'(shreg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= num;
        rem   <= 32'd0;
        dvs   <= den;
      end else if (busy) begin
        rem   <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        shreg <= {shreg[NUM_W-2:0], fits};
        cnt   <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient saturates at 2^31-1
  assign quo = (q64 > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q64[31:0];

endmodule

// File: src/critically_damped_smoother_unit.sv
// Channel  | Dir | Fields (low bit first)
// s_       | in  | tdata: current_value[31:0], target_value[63:32], time_step[95:64]
// m_       | out | tdata: new_value[31:0], velocity_out[63:32]; tuser: snapped
// cfg_     | in  | index 0 smooth_time (32b), index 1 max_speed (31b)
//
// One word at a time; each item runs its steps in order through the bit-serial
// multiplier and divider before the next word is accepted.
// Synchronous reset clears velocity, config to defaults, and both channels.
// A result waiting on m_ never blocks acceptance once the unit is idle again;
// the unit holds in its final step only when the output register is still full.
// Depends on cds_pkg, cds_mul, cds_div.
`timescale 1ns / 1ps

module critically_damped_smoother_unit #(
  parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // current_value, target_value, time_step
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // new_value, velocity_out
  output logic        m_tuser,   // snapped
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NUM_W = 2 * FRAC_BITS + 2;

  localparam logic [31:0] ONE   = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] C048  = 32'((64'd48 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] C0235 = 32'((64'd235 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic CFG_SMOOTH = 1'b0;
  localparam logic CFG_SPEED  = 1'b1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Operation steps
  localparam logic [3:0] OP_OMEGA = 4'd0;
  localparam logic [3:0] OP_X     = 4'd1;
  localparam logic [3:0] OP_X2    = 4'd2;
  localparam logic [3:0] OP_X3    = 4'd3;
  localparam logic [3:0] OP_T1    = 4'd4;
  localparam logic [3:0] OP_T2    = 4'd5;
  localparam logic [3:0] OP_DECAY = 4'd6;
  localparam logic [3:0] OP_LIMIT = 4'd7;
  localparam logic [3:0] OP_M1    = 4'd8;
  localparam logic [3:0] OP_TEMP  = 4'd9;
  localparam logic [3:0] OP_M2    = 4'd10;
  localparam logic [3:0] OP_VEL   = 4'd11;
  localparam logic [3:0] OP_M3    = 4'd12;

  logic [1:0] state;
  logic [3:0] op;

  logic [31:0] smooth_time;
  logic [30:0] max_speed;
  logic signed [31:0] velocity;

  logic signed [31:0] cur;
  logic signed [31:0] tgt;
  logic [31:0]        dt;
  logic signed [32:0] diff;
  logic [31:0] omega, x, x2, x3, den, decay;
  logic signed [31:0] change, temp, vel, s, result;
  logic signed [32:0] base;

  logic               out_valid;
  logic signed [31:0] out_value;
  logic signed [31:0] out_vel;
  logic               out_snap;

  logic [31:0]        st_eff;
  cds_pkg::mul_req_t  mul_req;
  logic               mul_start, mul_done;
  logic signed [31:0] mul_res;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num;
  logic [31:0]        div_den;
  logic [31:0]        div_q;
  logic               is_div;
  logic               snap;

  assign st_eff = (smooth_time == 32'd0) ? 32'd1 : smooth_time;
  assign is_div = (op == OP_OMEGA) || (op == OP_DECAY);
  assign snap   = ((tgt > cur) == (result > tgt));

  // Operand selection for the current step
  always_comb begin
    mul_req = '0;
    case (op)
      OP_X:     begin mul_req.a = omega; mul_req.b = dt; end
      OP_X2:    begin mul_req.a = x;     mul_req.b = x;  end
      OP_X3:    begin mul_req.a = x2;    mul_req.b = x;  end
      OP_T1:    begin mul_req.a = C048;  mul_req.b = x2; end
      OP_T2:    begin mul_req.a = C0235; mul_req.b = x3; end
      OP_LIMIT: begin mul_req.a = {1'b0, max_speed}; mul_req.b = st_eff; end
      OP_M1: begin
        mul_req.a = cds_pkg::abs32(change); mul_req.b = omega; mul_req.neg = change[31];
      end
      OP_TEMP: begin
        mul_req.a = cds_pkg::abs32(temp); mul_req.b = dt; mul_req.neg = temp[31];
      end
      OP_M2: begin
        mul_req.a = cds_pkg::abs32(temp); mul_req.b = omega; mul_req.neg = temp[31];
      end
      OP_VEL: begin
        mul_req.a = cds_pkg::abs32(vel); mul_req.b = decay; mul_req.neg = vel[31];
      end
      OP_M3: begin
        mul_req.a = cds_pkg::abs32(s); mul_req.b = decay; mul_req.neg = s[31];
      end
      default: mul_req = '0;
    endcase
  end

  assign mul_start = (state == ST_ISSUE) && !is_div;
  assign div_start = (state == ST_ISSUE) && is_div;
  assign div_num   = (op == OP_OMEGA) ? (NUM_W'(1) << (2 * FRAC_BITS + 1))
                                      : (NUM_W'(1) << (2 * FRAC_BITS));
  assign div_den   = (op == OP_OMEGA) ? st_eff : den;

  cds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .res   (mul_res)
  );

  cds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_time <= ONE;
      max_speed   <= 31'h7FFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMOOTH: smooth_time <= cfg_data;
        CFG_SPEED:  max_speed   <= cfg_data[30:0];
        default:    ;
      endcase
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_OMEGA;
      velocity  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && (state != ST_FIN)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur   <= s_tdata[31:0];
            tgt   <= s_tdata[63:32];
            dt    <= s_tdata[95:64];
            diff  <= $signed({s_tdata[31], s_tdata[31:0]})
                     - $signed({s_tdata[63], s_tdata[63:32]});
            op    <= OP_OMEGA;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done || div_done) begin
            case (op)
              OP_OMEGA: omega <= div_q;
              OP_X:     x     <= mul_res;
              OP_X2: begin
                x2  <= mul_res;
                den <= cds_pkg::usat_add(ONE, x);
              end
              OP_X3:    x3    <= mul_res;
              OP_T1:    den   <= cds_pkg::usat_add(den, mul_res);
              OP_T2:    den   <= cds_pkg::usat_add(den, mul_res);
              OP_DECAY: decay <= div_q;
              OP_LIMIT: begin
                // clamp offset to +-limit
                if (diff > $signed({1'b0, mul_res})) change <= mul_res;
                else if (diff < -$signed({1'b0, mul_res})) change <= ~mul_res + 32'd1;
                else change <= diff[31:0];
              end
              OP_M1: begin
                temp <= cds_pkg::sat32(34'(velocity) + 34'(mul_res));
                base <= 33'(cur) - 33'(change);
              end
              OP_TEMP:  temp <= mul_res;
              OP_M2: begin
                vel <= cds_pkg::sat32(34'(velocity) - 34'(mul_res));
                s   <= cds_pkg::sat32(34'(change) + 34'(temp));
              end
              OP_VEL:   vel    <= mul_res;
              OP_M3:    result <= cds_pkg::sat32(34'(base) + 34'(mul_res));
              default:  ;
            endcase
            if (op == OP_M3) state <= ST_FIN;
            else begin
              op    <= op + 4'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_FIN: begin
          // overshoot snaps to target and stops
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_value <= snap ? tgt : result;
            out_vel   <= snap ? 32'sd0 : vel;
            out_snap  <= snap;
            velocity  <= snap ? 32'sd0 : vel;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_vel, out_value};
  assign m_tuser  = out_snap;

endmodule

// File: src/cds_checker.sv
// Port-level checks for critically_damped_smoother_unit, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module cds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [95:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [31:0] cfg_data
);

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  // One word in flight: ready drops after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  // A snapped result carries zero velocity
  a_snap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[63:32] == 32'd0)
    else $error("snapped result with velocity");

endmodule

bind critically_damped_smoother_unit cds_checker u_cds_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for critically_damped_smoother_unit: stream stimulus, random idling
// on both channels, and a scoreboard class with its own fixed-point copy of the smoother.
// Depends on cds_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int FB = cds_pkg::FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam int N_RANDOM = 1950;
  localparam int N_PHASES = 6;

  // Register indexes
  localparam logic REG_SMOOTH_TIME = 1'b0;
  localparam logic REG_MAX_SPEED   = 1'b1;

  typedef struct {
    logic signed [31:0] new_value;
    logic signed [31:0] velocity;
    logic               snapped;
  } smoothed_t;

  // Scoreboard: fixed-point smoother model plus the queue of pending results
  class smoother_scoreboard;
    bit [31:0]          smooth_time;
    bit [30:0]          max_speed;
    logic signed [31:0] velocity;
    smoothed_t          pending_q[$];
    int unsigned        errors;
    int unsigned        n_checked;
    int unsigned        n_snaps;

    function new();
      smooth_time = 32'd65536;
      max_speed   = 31'h7FFF_FFFF;
      velocity    = '0;
      errors      = 0;
      n_checked   = 0;
      n_snaps     = 0;
    endfunction

    function void write_reg(logic idx, bit [31:0] val);
      if (idx == REG_SMOOTH_TIME) smooth_time = val;
      else max_speed = val[30:0];
    endfunction

    function longint clamp_s32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function bit [63:0] clamp_u31(bit [63:0] v);
      return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
    endfunction

    // (a*b) >> FB with truncation toward zero, saturated
    function longint qmul(longint a, bit [63:0] b);
      bit        neg;
      bit [63:0] mag;
      bit [63:0] p;
      neg = a < 0;
      mag = neg ? 64'(-a) : 64'(a);
      p = (mag * b) >> FB;
      if (neg) begin
        if (p > 64'h8000_0000) p = 64'h8000_0000;
        return -longint'(p);
      end
      return longint'(clamp_u31(p));
    endfunction

    function void note_input(logic signed [31:0] cur_v, logic signed [31:0] tgt_v,
                             logic [31:0] dt_v);
      bit [63:0] c048, c0235, st, dt, omega, x, x2, x3, den, decay, limit;
      longint    cur, tgt, change, temp, vel, res;
      bit        snap;
      smoothed_t e;
      c048  = (64'd48 * (64'd1 << FB) + 64'd50) / 64'd100;
      c0235 = (64'd235 * (64'd1 << FB) + 64'd500) / 64'd1000;
      cur = cur_v;
      tgt = tgt_v;
      dt = dt_v;
      st = (smooth_time == 0) ? 64'd1 : smooth_time;
      omega = clamp_u31((64'd2 << (2 * FB)) / st);
      x  = clamp_u31((omega * dt) >> FB);
      x2 = clamp_u31((x * x) >> FB);
      x3 = clamp_u31((x2 * x) >> FB);
      den = clamp_u31((64'd1 << FB) + x);
      den = clamp_u31(den + clamp_u31((c048 * x2) >> FB));
      den = clamp_u31(den + clamp_u31((c0235 * x3) >> FB));
      decay = (64'd1 << (2 * FB)) / den;
      limit = clamp_u31((64'(max_speed) * st) >> FB);
      change = cur - tgt;
      if (change > longint'(limit)) change = longint'(limit);
      if (change < -longint'(limit)) change = -longint'(limit);
      temp = clamp_s32(longint'(velocity) + qmul(change, omega));
      temp = qmul(temp, dt);
      vel = clamp_s32(longint'(velocity) - qmul(temp, omega));
      vel = qmul(vel, decay);
      res = clamp_s32((cur - change) + qmul(clamp_s32(change + temp), decay));
      // overshoot catch: snap to target and zero the velocity
      snap = ((tgt > cur) == (res > tgt));
      if (snap) begin
        res = tgt;
        vel = 0;
      end
      velocity = vel[31:0];
      e.new_value = res[31:0];
      e.velocity  = vel[31:0];
      e.snapped   = snap;
      pending_q.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] nv, logic signed [31:0] vel, logic snp);
      smoothed_t e;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: new_value %0d", nv);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (e.snapped) n_snaps++;
      if (nv !== e.new_value) begin
        $error("new_value: expected %0d, actual %0d", e.new_value, nv);
        errors++;
      end
      if (vel !== e.velocity) begin
        $error("velocity_out: expected %0d, actual %0d", e.velocity, vel);
        errors++;
      end
      if (snp !== e.snapped) begin
        $error("snapped: expected %0b, actual %0b", e.snapped, snp);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // current_value, target_value, time_step
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // new_value, velocity_out
  logic        m_tuser;   // snapped
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  smoother_scoreboard sb;
  bit          calm;          // no idling on either side
  int unsigned quiet_cycles;
  int unsigned n_sent;

  critically_damped_smoother_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output monitor and watchdog
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts unless calm
  initial begin
    m_tready = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  // Drop valid so nothing more is taken, then wait for every result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Send one word; valid stays high into the next word unless a gap is taken
  task automatic send_word(logic [31:0] cur, logic [31:0] tgt, logic [31:0] dt);
    s_tvalid <= 1'b1;
    s_tdata  <= {dt, tgt, cur};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(cur, tgt, dt);
    n_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_value(logic [31:0] near);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return near;
      default: return near + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'd0;
      2: return $urandom_range(1, 16);
      default: return $urandom_range(1, 32'h0000_8000);
    endcase
  endfunction

  task automatic run_phase(int n);
    logic [31:0] cur, tgt;
    cur = $urandom();
    tgt = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) tgt = $urandom();
      cur = rand_value(cur);
      send_word(cur, rand_value(tgt), rand_step());
    end
  endtask

  initial begin
    logic [31:0] st_set[N_PHASES];
    logic [31:0] ms_set[N_PHASES];
    sb = new();
    calm = 1'b0;
    n_sent = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SMOOTH_TIME;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at reset settings: extremes, equal values, zero step
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0000_4000);
    send_word(32'h0000_0000, 32'h0010_0000, 32'h0000_0000);
    send_word(32'h0000_0000, 32'h0010_0000, 32'h0000_1000);
    send_word(32'h0004_0000, 32'h0010_0000, 32'h0000_1000);
    send_word(32'hFFF0_0000, 32'h0000_0000, 32'h0000_0001);
    send_word(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0800);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    wait_drained();
    // Tightest rate limit and shortest smooth time
    write_reg(REG_SMOOTH_TIME, 32'd1);
    write_reg(REG_MAX_SPEED, 32'd0);
    send_word(32'h0010_0000, 32'h0000_0000, 32'h0000_0100);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    // Zero smooth time, treated as the smallest step
    write_reg(REG_SMOOTH_TIME, 32'd0);
    write_reg(REG_MAX_SPEED, 32'h7FFF_FFFF);
    send_word(32'h0010_0000, 32'h0000_0000, 32'h0000_0100);
    send_word(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
    wait_drained();
    // Longest smooth time
    write_reg(REG_SMOOTH_TIME, 32'hFFFF_FFFF);
    send_word(32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(32'h0000_0001, 32'h0000_0000, 32'h0000_8000);
    wait_drained();

    // Random phases across several settings; the last one runs without idling
    st_set = '{32'h0001_0000, 32'h0000_4000, 32'hFFFF_FFFF, 32'd1, 32'h0004_0000, 32'h0000_8000};
    ms_set = '{32'h7FFF_FFFF, 32'h0000_8000, 32'd0, 32'h0100_0000, 32'h7FFF_FFFF, 32'h0020_0000};
    for (int p = 0; p < N_PHASES; p++) begin
      s_tvalid <= 1'b0;
      wait_drained();
      if (p == 3) begin
        write_reg(REG_SMOOTH_TIME, $urandom());
        write_reg(REG_MAX_SPEED, $urandom());
      end else begin
        write_reg(REG_SMOOTH_TIME, st_set[p]);
        write_reg(REG_MAX_SPEED, ms_set[p]);
      end
      if (p == N_PHASES - 1) calm = 1'b1;
      run_phase(N_RANDOM / N_PHASES);
    end
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d words (%0d results checked, %0d snaps) over ten register settings",
             n_sent, sb.n_checked, sb.n_snaps);
    $display("with extreme values, zero steps and random stalls on both channels.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cds_pkg.sv
src/cds_mul.sv
src/cds_div.sv
src/critically_damped_smoother_unit.sv
src/cds_checker.sv
bench/testbench.sv
